// File: sv/mmcrc_pkg.sv
// ----------------------------------------------------------------------------
// mmcrc_pkg: shared types and constants for the multi-mode CRC engine
// Kind codes, polynomials, init values and the per-byte fold functions.
// ----------------------------------------------------------------------------
package mmcrc_pkg;

  typedef enum logic [1:0] {
    KindNone  = 2'd0,
    KindCrc8  = 2'd1,
    KindCrc16 = 2'd2,
    KindCrc32 = 2'd3
  } crc_kind_e;

  localparam int unsigned AccWidth = 32;

  localparam logic [7:0]  Poly8     = 8'h07;
  localparam logic [15:0] Poly16    = 16'h1021;
  localparam logic [31:0] Poly32Ref = 32'hEDB88320;

  localparam logic [31:0] Init8  = 32'h0000_0000;
  localparam logic [31:0] Init16 = 32'h0000_FFFF;
  localparam logic [31:0] Init32 = 32'hFFFF_FFFF;
  localparam logic [31:0] Xor32  = 32'hFFFF_FFFF;

  // CRC-8, MSB first, one byte folded in
  function automatic logic [7:0] fold8(logic [7:0] acc, logic [7:0] data);
    logic [7:0] r;
    r = acc ^ data;
    for (int b = 0; b < 8; b++) begin
      r = r[7] ? ({r[6:0], 1'b0} ^ Poly8) : {r[6:0], 1'b0};
    end
    return r;
  endfunction

  // CRC-16 CCITT, MSB first, byte enters the top
  function automatic logic [15:0] fold16(logic [15:0] acc, logic [7:0] data);
    logic [15:0] r;
    r = acc ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ Poly16) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  // CRC-32 reflected, LSB first
  function automatic logic [31:0] fold32(logic [31:0] acc, logic [7:0] data);
    logic [31:0] r;
    r = acc ^ {24'h000000, data};
    for (int b = 0; b < 8; b++) begin
      r = r[0] ? ({1'b0, r[31:1]} ^ Poly32Ref) : {1'b0, r[31:1]};
    end
    return r;
  endfunction

endpackage

// File: sv/mmcrc_fold.sv
// ----------------------------------------------------------------------------
// mmcrc_fold: per-byte CRC update
// Picks the start value, folds one byte by the selected kind and forms the
// finished CRC for the case where the byte closes the message.
// ----------------------------------------------------------------------------
module mmcrc_fold (
  input  mmcrc_pkg::crc_kind_e kind_i,
  input  logic                 in_msg_i,
  input  logic [31:0]          acc_i,
  input  logic [7:0]           data_byte_i,
  output logic [31:0]          acc_next_o,
  output logic [31:0]          crc_final_o
);

  logic [31:0] base;

  // start value: running CRC, or the kind's init on a first byte
  always_comb begin
    if (in_msg_i) begin
      base = acc_i;
    end else begin
      unique case (kind_i)
        mmcrc_pkg::KindCrc16: base = mmcrc_pkg::Init16;
        mmcrc_pkg::KindCrc32: base = mmcrc_pkg::Init32;
        default:              base = mmcrc_pkg::Init8;
      endcase
    end
  end

  // fold the byte in; narrow kinds truncate the accumulator first
  always_comb begin
    unique case (kind_i)
      mmcrc_pkg::KindCrc8:
        acc_next_o = {24'h000000, mmcrc_pkg::fold8(base[7:0], data_byte_i)};
      mmcrc_pkg::KindCrc16:
        acc_next_o = {16'h0000, mmcrc_pkg::fold16(base[15:0], data_byte_i)};
      mmcrc_pkg::KindCrc32:
        acc_next_o = mmcrc_pkg::fold32(base, data_byte_i);
      default:
        acc_next_o = base;
    endcase
  end

  // finished value: final xor for CRC-32, zero for no CRC
  always_comb begin
    unique case (kind_i)
      mmcrc_pkg::KindNone:  crc_final_o = '0;
      mmcrc_pkg::KindCrc32: crc_final_o = acc_next_o ^ mmcrc_pkg::Xor32;
      default:              crc_final_o = acc_next_o;
    endcase
  end

endmodule

// File: sv/multi_mode_crc_engine_core.sv
// ----------------------------------------------------------------------------
// multi_mode_crc_engine_core: streaming CRC-8 / CRC-16 / CRC-32 engine
// Folds one message byte per cycle while not stalled into a running CRC and
// emits the finished CRC on the last byte of each message.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+-----------------------------
//  in      | sink      | in_valid_i/in_stall_o | data_byte_i, last_byte_i
//  out     | source    | out_valid_o/out_stall_i | crc_value_o
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_data_i (crc_kind)
//
// One byte is accepted per cycle unless in_stall_o is high; the fold is a
// single pass of XOR logic between the input register and the accumulator /
// result register; result valid is set as the last byte leaves the input stage.
// Reset clears the kind to none, the accumulator and the message flag.
// in_stall_o rises only when the input register holds a last byte while the
// result register is full and stalled; other bytes always drain.
// ----------------------------------------------------------------------------
module multi_mode_crc_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] crc_value_o,
  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i
);

  mmcrc_pkg::crc_kind_e kind_q;

  logic        s1_valid_q, s1_valid_d;
  logic [7:0]  s1_byte_q;
  logic        s1_last_q;
  logic        s1_adv;
  logic        in_accept;

  logic [31:0] acc_q, acc_d;
  logic        msg_q, msg_d;
  logic [31:0] acc_next;
  logic [31:0] crc_final;

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_crc_q;

  // configuration register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= mmcrc_pkg::KindNone;
    end else if (cfg_valid_i && cfg_ready_o) begin
      kind_q <= mmcrc_pkg::crc_kind_e'(cfg_data_i);
    end
  end

  // input register handshake; only a last byte waits on the result register
  assign s1_adv     = s1_valid_q && (!s1_last_q || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // input word payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  // byte fold
  mmcrc_fold u_fold (
    .kind_i      (kind_q),
    .in_msg_i    (msg_q),
    .acc_i       (acc_q),
    .data_byte_i (s1_byte_q),
    .acc_next_o  (acc_next),
    .crc_final_o (crc_final)
  );

  // running CRC; cleared when a message closes
  always_comb begin
    acc_d = acc_q;
    msg_d = msg_q;
    if (s1_adv) begin
      if (s1_last_q) begin
        acc_d = '0;
        msg_d = 1'b0;
      end else begin
        acc_d = acc_next;
        msg_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      msg_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      msg_q <= msg_d;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv && s1_last_q) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      out_crc_q <= crc_final;
    end
  end

  assign out_valid_o = out_valid_q;
  assign crc_value_o = out_crc_q;

  // checks
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_last_q && out_valid_q))
    else $error("input stalled without a blocked last byte");

  a_mid_msg_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !s1_last_q) |=> msg_q)
    else $error("message flag not set after a middle byte");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_last_q) |=> (!msg_q && acc_q == '0 && out_valid_q))
    else $error("message close did not re-arm or post a result");

  a_none_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_last_q && kind_q == mmcrc_pkg::KindNone) |=> (out_crc_q == '0))
    else $error("no-CRC kind gave a non-zero result");

endmodule

// File: test/tb_multi_mode_crc_engine_core.sv
// ----------------------------------------------------------------------------
// tb_multi_mode_crc_engine_core: self-checking bench for the multi-mode CRC engine
// Streams message bytes through the engine under each CRC kind. It changes the
// kind between messages and in the middle of them, and holds off the result
// side to force input stalls. Every finished CRC is compared with a bitwise
// CRC calculation kept inside the bench.
// ----------------------------------------------------------------------------
module tb_multi_mode_crc_engine_core;

  localparam logic [31:0] Crc8Poly      = 32'h0000_0007;
  localparam logic [31:0] Crc16Poly     = 32'h0000_1021;
  localparam logic [31:0] Crc32PolyRefl = 32'hEDB8_8320;
  localparam logic [31:0] Crc16Seed     = 32'h0000_FFFF;
  localparam logic [31:0] Crc32Seed     = 32'hFFFF_FFFF;
  localparam int          CycleLimit    = 300000;
  localparam int          RandomBytes   = 900;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] crc_value_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i  = 2'd0;

  // bench copy of the engine state
  mmcrc_pkg::crc_kind_e kind_sel_q = mmcrc_pkg::KindNone;
  logic [31:0] crc_acc_q  = 32'h0;
  logic        msg_open_q = 1'b0;
  logic [31:0] crc_expected_q[$];

  logic [31:0] exp_crc;
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int          rx_hold_cycles = 0;
  bit          idle_on        = 1'b1;

  multi_mode_crc_engine_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .crc_value_o (crc_value_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // one byte folded into the running CRC by the given kind, bit by bit
  function automatic logic [31:0] crc_fold_byte(mmcrc_pkg::crc_kind_e k,
                                                logic [31:0] acc, logic [7:0] b);
    logic [31:0] r;
    r = acc;
    case (k)
      mmcrc_pkg::KindCrc8: begin
        r = {24'h0, acc[7:0] ^ b};
        repeat (8) r = r[7] ? ({24'h0, r[6:0], 1'b0} ^ Crc8Poly) : {24'h0, r[6:0], 1'b0};
      end
      mmcrc_pkg::KindCrc16: begin
        r = {16'h0, acc[15:0] ^ {b, 8'h00}};
        repeat (8) begin
          r = r[15] ? ({16'h0, r[14:0], 1'b0} ^ Crc16Poly) : {16'h0, r[14:0], 1'b0};
        end
      end
      mmcrc_pkg::KindCrc32: begin
        r = acc ^ {24'h0, b};
        repeat (8) r = r[0] ? ((r >> 1) ^ Crc32PolyRefl) : (r >> 1);
      end
      default: r = acc;
    endcase
    return r;
  endfunction

  // track one accepted byte; a last byte queues the finished CRC
  function automatic void absorb_byte(logic [7:0] b, logic l);
    logic [31:0] acc;
    if (msg_open_q) acc = crc_acc_q;
    else if (kind_sel_q == mmcrc_pkg::KindCrc16) acc = Crc16Seed;
    else if (kind_sel_q == mmcrc_pkg::KindCrc32) acc = Crc32Seed;
    else acc = 32'h0;
    acc = crc_fold_byte(kind_sel_q, acc, b);
    if (!l) begin
      crc_acc_q  = acc;
      msg_open_q = 1'b1;
    end else begin
      if (kind_sel_q == mmcrc_pkg::KindCrc32) crc_expected_q.push_back(acc ^ Crc32Seed);
      else if (kind_sel_q == mmcrc_pkg::KindNone) crc_expected_q.push_back(32'h0);
      else crc_expected_q.push_back(acc);
      crc_acc_q  = 32'h0;
      msg_open_q = 1'b0;
    end
  endfunction

  // offer one word after a random gap (none when idling is off) and wait until the engine takes it
  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= l;
    do @(posedge clk_i); while (in_stall_o);
    absorb_byte(b, l);
  endtask

  // stop offering, let every result out and give the pipe time to empty
  task automatic drain_engine();
    in_valid_i <= 1'b0;
    while (crc_expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_kind(input mmcrc_pkg::crc_kind_e k);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= k;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    kind_sel_q = k;
  endtask

  // result side: random stall per word when idling is on, or a long hold when asked
  initial begin
    int n;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end else if (idle_on) begin
        n = $urandom_range(0, 15);
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o && rx_hold_cycles == 0);
    end
  end

  // compare each word taken from the engine with the oldest expected CRC
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (crc_expected_q.size() == 0) begin
        $display("%0t: unexpected crc word, expected none, got %08h", $time, crc_value_o);
        mismatch_count++;
      end else begin
        exp_crc = crc_expected_q.pop_front();
        if (crc_value_o !== exp_crc) begin
          $display("%0t: crc mismatch, expected %08h, got %08h", $time, exp_crc,
                   crc_value_o);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // kind after reset must be none: CRC reads zero
  task automatic test_reset_kind();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // each real kind: all-ones then all-zeros, and a one-byte message
  task automatic test_each_kind();
    mmcrc_pkg::crc_kind_e k;
    k = mmcrc_pkg::KindCrc8;
    repeat (3) begin
      drain_engine();
      write_kind(k);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h5A, 1'b1);
      k = mmcrc_pkg::crc_kind_e'(k + 2'd1);
    end
  endtask

  // kind swapped mid message: no reseeding, accumulator cut to the new width
  task automatic test_kind_switch_in_message();
    drain_engine();
    write_kind(mmcrc_pkg::KindCrc32);
    send_byte(8'h31, 1'b0);
    drain_engine();
    write_kind(mmcrc_pkg::KindCrc8);
    send_byte(8'h32, 1'b0);
    drain_engine();
    write_kind(mmcrc_pkg::KindCrc16);
    send_byte(8'h33, 1'b0);
    drain_engine();
    write_kind(mmcrc_pkg::KindNone);
    send_byte(8'h34, 1'b1);
    drain_engine();
    write_kind(mmcrc_pkg::KindCrc8);
    send_byte(8'hC3, 1'b0);
    drain_engine();
    write_kind(mmcrc_pkg::KindCrc32);
    send_byte(8'h7E, 1'b1);
    // none in the middle leaves the running CRC alone
    drain_engine();
    write_kind(mmcrc_pkg::KindCrc16);
    send_byte(8'h11, 1'b0);
    drain_engine();
    write_kind(mmcrc_pkg::KindNone);
    send_byte(8'h22, 1'b0);
    drain_engine();
    write_kind(mmcrc_pkg::KindCrc16);
    send_byte(8'h33, 1'b1);
  endtask

  // result side held off while short messages keep coming: input must stall
  task automatic test_back_pressure();
    drain_engine();
    idle_on = 1'b0;
    rx_hold_cycles = 300;
    for (int i = 0; i < 40; i++) begin
      send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) != 0));
    end
    drain_engine();
    idle_on = 1'b1;
  endtask

  // random messages in phases of different kind and idling
  task automatic test_random_messages();
    int sent;
    int phase;
    int len;
    logic [7:0] b;
    sent  = 0;
    phase = 0;
    while (sent < RandomBytes) begin
      if (sent >= phase * 120) begin
        drain_engine();
        idle_on = (phase % 3) != 2;
        write_kind(mmcrc_pkg::crc_kind_e'($urandom_range(0, 3)));
        phase++;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        if (i > 0 && $urandom_range(0, 59) == 0) begin
          drain_engine();
          write_kind(mmcrc_pkg::crc_kind_e'($urandom_range(0, 3)));
        end
        if ($urandom_range(0, 7) == 0) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else b = 8'($urandom_range(0, 255));
        send_byte(b, i == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_kind();
    test_each_kind();
    test_kind_switch_in_message();
    test_back_pressure();
    test_random_messages();
    drain_engine();
    repeat (8) @(posedge clk_i);
    if (crc_expected_q.size() != 0) begin
      $display("%0t: %0d crc words missing, expected %08h, got none", $time,
               crc_expected_q.size(), crc_expected_q[0]);
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
